FILE: sv/fptl_pkg.sv
// shared codes, result type and keyword tables for the footprint token lexer
package fptl_pkg;

    // default width of the number accumulator
    localparam int FPTL_NUMBER_WIDTH = 32;

    // token kinds on the result channel
    localparam logic [3:0] KIND_NUMBER      = 4'd0;
    localparam logic [3:0] KIND_SCHAR       = 4'd1;
    localparam logic [3:0] KIND_SEND        = 4'd2;
    localparam logic [3:0] KIND_LPAREN      = 4'd3;
    localparam logic [3:0] KIND_RPAREN      = 4'd4;
    localparam logic [3:0] KIND_LBRACK      = 4'd5;
    localparam logic [3:0] KIND_RBRACK      = 4'd6;
    localparam logic [3:0] KIND_ELEMENTLINE = 4'd7;
    localparam logic [3:0] KIND_ELEMENT     = 4'd9;
    localparam logic [3:0] KIND_EOF         = 4'd12;
    localparam logic [3:0] KIND_ERROR       = 4'd13;

    // scanner states
    localparam logic [3:0] MODE_IDLE    = 4'd0;
    localparam logic [3:0] MODE_SIGN    = 4'd1;
    localparam logic [3:0] MODE_DEC     = 4'd2;
    localparam logic [3:0] MODE_ZERO    = 4'd3;
    localparam logic [3:0] MODE_ZERO_W  = 4'd4;
    localparam logic [3:0] MODE_HEX_X   = 4'd5;
    localparam logic [3:0] MODE_HEX     = 4'd6;
    localparam logic [3:0] MODE_KEYWORD = 4'd7;
    localparam logic [3:0] MODE_STRING  = 4'd8;

    // keyword table: elementline, elementarc, element, pad, pin
    localparam int         KW_COUNT       = 5;
    localparam logic [3:0] KW_ELEMENT_LEN = 4'd7;
    localparam logic [4:0] KW_CAND_E      = 5'b00111;
    localparam logic [4:0] KW_CAND_P      = 5'b11000;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic        ovf;
        logic [7:0]  ch;
    } token_t;

    // keyword text, left aligned and zero padded
    function automatic logic [87:0] kw_text(input logic [2:0] k);
        logic [87:0] t;
        unique case (k)
            3'd0:    t = "elementline";
            3'd1:    t = {"elementarc", 8'h00};
            3'd2:    t = {"element", 32'h0};
            3'd3:    t = {"pad", 64'h0};
            3'd4:    t = {"pin", 64'h0};
            default: t = '0;
        endcase
        return t;
    endfunction

    // byte at position p of keyword k
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] p);
        logic [87:0] shifted;
        shifted = kw_text(k) << {p, 3'b000};
        return shifted[87:80];
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] n;
        unique case (k)
            3'd0:    n = 4'd11;
            3'd1:    n = 4'd10;
            3'd2:    n = 4'd7;
            3'd3:    n = 4'd3;
            3'd4:    n = 4'd3;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: sv/footprint_token_lexer_core.sv
// footprint token lexer: byte scanner with a four-entry result queue
// Results of a request are registered into the result queue; m_ shows the queue head.
// Throughput: one request per cycle while each gives at most one result and m_ready is
// held high; the two results of a request leave one at a time through the single result port.
// The request side is ready while the result queue has room for two entries.
// Reset: aresetn (synchronous, active low) clears the scan state and empties the queue.
module footprint_token_lexer_core #(
    parameter int NUMBER_WIDTH = fptl_pkg::FPTL_NUMBER_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_byte,
    input  logic               s_end_of_input,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_token_kind,
    output logic signed [31:0] m_number_value,
    output logic               m_number_overflow,
    output logic [7:0]         m_string_char,
    output logic               m_last_of_run
);

    localparam int AccW  = NUMBER_WIDTH;
    localparam int ProdW = NUMBER_WIDTH + 4;
    localparam int ExtW  = (NUMBER_WIDTH > 32) ? NUMBER_WIDTH : 32;
    localparam logic [AccW-1:0] CAP = {1'b1, {(AccW-1){1'b0}}};

    typedef struct packed {
        fptl_pkg::token_t tok;
        logic             last;
    } entry_t;

    function automatic fptl_pkg::token_t mk_tok(input logic [3:0] kind);
        fptl_pkg::token_t t;
        t.kind  = kind;
        t.value = '0;
        t.ovf   = 1'b0;
        t.ch    = 8'h00;
        return t;
    endfunction

    // scan state
    logic [3:0]      mode_reg, mode_next;
    logic [3:0]      kw_prog_reg, kw_prog_next;
    logic [4:0]      kw_cand_reg, kw_cand_next;
    logic            prev_word_reg, prev_word_next;
    logic            prev_space_reg, prev_space_next;
    logic [AccW-1:0] acc_reg, acc_next;
    logic            neg_reg, neg_next;
    logic            ovf_reg, ovf_next;
    logic            esc_reg, esc_next;
    logic            err_reg, err_next;

    // result queue
    entry_t     fifo_reg [4];
    logic [1:0] head_reg, tail_reg;
    logic [2:0] count_reg;

    logic accept, pop, end_in;

    // byte classes
    logic [7:0] c, lc, str_ch;
    logic       is_dig, is_alpha, is_word, is_space, is_x, hex_ok;
    logic [3:0] dig_d, hex_d;

    assign c        = s_char_byte;
    assign lc       = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    assign is_dig   = (c >= "0" && c <= "9");
    assign is_alpha = (lc >= "a" && lc <= "z");
    assign is_word  = is_dig || is_alpha || (c == "_");
    assign is_space = (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
    assign is_x     = (lc == "x");
    assign hex_ok   = is_dig || (lc >= "a" && lc <= "f");
    assign dig_d    = c[3:0];
    assign hex_d    = is_dig ? c[3:0] : c[3:0] + 4'd9;
    assign str_ch   = is_space ? 8'h20 : c;
    assign end_in   = s_end_of_input || (c == 8'h00);

    // handling of a byte between tokens
    logic       id_v, id_err, id_start, id_neg, id_kw, id_str;
    logic [3:0] id_kind, id_mode, id_d;
    logic [4:0] id_cand;

    always_comb begin
        id_v     = 1'b0;
        id_kind  = fptl_pkg::KIND_ERROR;
        id_err   = 1'b0;
        id_mode  = fptl_pkg::MODE_IDLE;
        id_start = 1'b0;
        id_neg   = 1'b0;
        id_d     = 4'd0;
        id_kw    = 1'b0;
        id_cand  = 5'b0;
        id_str   = 1'b0;
        priority if (is_space) begin
        end else if (c == "\"") begin
            id_mode = fptl_pkg::MODE_STRING;
            id_str  = 1'b1;
        end else if (c == "(") begin
            id_v    = 1'b1;
            id_kind = fptl_pkg::KIND_LPAREN;
        end else if (c == ")") begin
            id_v    = 1'b1;
            id_kind = fptl_pkg::KIND_RPAREN;
        end else if (c == "[") begin
            id_v    = 1'b1;
            id_kind = fptl_pkg::KIND_LBRACK;
        end else if (c == "]") begin
            id_v    = 1'b1;
            id_kind = fptl_pkg::KIND_RBRACK;
        end else if (c == "+" || c == "-") begin
            id_mode  = fptl_pkg::MODE_SIGN;
            id_start = 1'b1;
            id_neg   = (c == "-");
        end else if (c == "0") begin
            id_mode  = prev_word_reg ? fptl_pkg::MODE_ZERO_W : fptl_pkg::MODE_ZERO;
            id_start = 1'b1;
        end else if (is_dig && !prev_word_reg) begin
            id_mode  = fptl_pkg::MODE_DEC;
            id_start = 1'b1;
            id_d     = dig_d;
        end else if (lc == "e") begin
            id_mode = fptl_pkg::MODE_KEYWORD;
            id_kw   = 1'b1;
            id_cand = fptl_pkg::KW_CAND_E;
        end else if (lc == "p") begin
            id_mode = fptl_pkg::MODE_KEYWORD;
            id_kw   = 1'b1;
            id_cand = fptl_pkg::KW_CAND_P;
        end else begin
            id_v   = 1'b1;
            id_err = 1'b1;
        end
    end

    // keyword candidate matching
    logic [4:0] kw_mask;
    logic [3:0] kw_inc;
    logic       kw_done_v, kw_longer;
    logic [2:0] kw_done_idx;

    assign kw_inc = kw_prog_reg + 4'd1;

    always_comb begin
        kw_mask     = 5'b0;
        kw_done_v   = 1'b0;
        kw_longer   = 1'b0;
        kw_done_idx = 3'd0;
        for (int k = 0; k < fptl_pkg::KW_COUNT; k++) begin
            kw_mask[k] = kw_cand_reg[k] && (kw_prog_reg < fptl_pkg::kw_len(3'(k)))
                         && (fptl_pkg::kw_char(3'(k), kw_prog_reg) == lc);
        end
        for (int k = 0; k < fptl_pkg::KW_COUNT; k++) begin
            if (kw_mask[k]) begin
                if (fptl_pkg::kw_len(3'(k)) == kw_inc) begin
                    kw_done_v   = 1'b1;
                    kw_done_idx = 3'(k);
                end else if (fptl_pkg::kw_len(3'(k)) > kw_inc) begin
                    kw_longer = 1'b1;
                end
            end
        end
    end

    // digit accumulation and number result
    logic             add_hex;
    logic [ProdW-1:0] prod;
    logic             add_ovf, num_ovf;
    logic [ExtW-1:0]  ext_acc, neg_acc;
    logic [31:0]      num_value;

    // hex digits in the hex states, decimal otherwise
    assign add_hex = (mode_reg == fptl_pkg::MODE_HEX_X) || (mode_reg == fptl_pkg::MODE_HEX);

    always_comb begin
        if (add_hex) begin
            prod = {acc_reg, 4'b0000} + ProdW'(hex_d);
        end else begin
            prod = (ProdW'(acc_reg) << 3) + (ProdW'(acc_reg) << 1) + ProdW'(dig_d);
        end
    end

    assign add_ovf   = prod > ProdW'(CAP);
    assign num_ovf   = ovf_reg || (!neg_reg && acc_reg == CAP);
    assign ext_acc   = ExtW'(acc_reg);
    assign neg_acc   = -ext_acc;
    assign num_value = num_ovf ? 32'd0 : (neg_reg ? neg_acc[31:0] : ext_acc[31:0]);

    // next state and up to two results
    logic             pre_v, sec_v, use_idle, do_add;
    fptl_pkg::token_t pre, sec;

    always_comb begin
        mode_next       = mode_reg;
        kw_prog_next    = kw_prog_reg;
        kw_cand_next    = kw_cand_reg;
        prev_word_next  = prev_word_reg;
        prev_space_next = prev_space_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        ovf_next        = ovf_reg;
        esc_next        = esc_reg;
        err_next        = err_reg;
        pre_v           = 1'b0;
        pre             = mk_tok(fptl_pkg::KIND_ERROR);
        sec_v           = 1'b0;
        sec             = mk_tok(fptl_pkg::KIND_ERROR);
        use_idle        = 1'b0;
        do_add          = 1'b0;

        if (end_in) begin
            // flush the pending token unless in error, then eof and full state clear
            if (!err_reg) begin
                unique case (mode_reg)
                    fptl_pkg::MODE_DEC, fptl_pkg::MODE_ZERO, fptl_pkg::MODE_HEX: begin
                        pre_v     = 1'b1;
                        pre       = mk_tok(fptl_pkg::KIND_NUMBER);
                        pre.value = num_value;
                        pre.ovf   = num_ovf;
                    end
                    fptl_pkg::MODE_KEYWORD: begin
                        pre_v = 1'b1;
                        pre   = mk_tok((kw_prog_reg == fptl_pkg::KW_ELEMENT_LEN) ?
                                       fptl_pkg::KIND_ELEMENT : fptl_pkg::KIND_ERROR);
                    end
                    fptl_pkg::MODE_IDLE: begin
                    end
                    default: begin
                        pre_v = 1'b1;
                    end
                endcase
            end
            sec_v           = 1'b1;
            sec             = mk_tok(fptl_pkg::KIND_EOF);
            mode_next       = fptl_pkg::MODE_IDLE;
            kw_prog_next    = 4'd0;
            kw_cand_next    = 5'b0;
            prev_word_next  = 1'b0;
            prev_space_next = 1'b0;
            acc_next        = '0;
            neg_next        = 1'b0;
            ovf_next        = 1'b0;
            esc_next        = 1'b0;
            err_next        = 1'b0;
        end else if (err_reg) begin
            pre_v = 1'b1;
        end else begin
            unique case (mode_reg)
                fptl_pkg::MODE_SIGN: begin
                    if (is_dig) begin
                        mode_next = fptl_pkg::MODE_DEC;
                        acc_next  = AccW'(dig_d);
                        ovf_next  = 1'b0;
                    end else begin
                        pre_v     = 1'b1;
                        err_next  = 1'b1;
                        mode_next = fptl_pkg::MODE_IDLE;
                    end
                end
                fptl_pkg::MODE_ZERO, fptl_pkg::MODE_DEC: begin
                    if (mode_reg == fptl_pkg::MODE_ZERO && is_x) begin
                        mode_next = fptl_pkg::MODE_HEX_X;
                    end else if (is_dig) begin
                        mode_next = fptl_pkg::MODE_DEC;
                        do_add    = 1'b1;
                    end else if (is_word) begin
                        pre_v     = 1'b1;
                        err_next  = 1'b1;
                        mode_next = fptl_pkg::MODE_IDLE;
                    end else begin
                        pre_v     = 1'b1;
                        pre       = mk_tok(fptl_pkg::KIND_NUMBER);
                        pre.value = num_value;
                        pre.ovf   = num_ovf;
                        use_idle  = 1'b1;
                    end
                end
                fptl_pkg::MODE_ZERO_W: begin
                    if (is_x) begin
                        mode_next = fptl_pkg::MODE_HEX_X;
                    end else begin
                        pre_v     = 1'b1;
                        err_next  = 1'b1;
                        mode_next = fptl_pkg::MODE_IDLE;
                    end
                end
                fptl_pkg::MODE_HEX_X, fptl_pkg::MODE_HEX: begin
                    if (hex_ok) begin
                        mode_next = fptl_pkg::MODE_HEX;
                        do_add    = 1'b1;
                    end else if (mode_reg == fptl_pkg::MODE_HEX_X || is_word) begin
                        pre_v     = 1'b1;
                        err_next  = 1'b1;
                        mode_next = fptl_pkg::MODE_IDLE;
                    end else begin
                        pre_v     = 1'b1;
                        pre       = mk_tok(fptl_pkg::KIND_NUMBER);
                        pre.value = num_value;
                        pre.ovf   = num_ovf;
                        use_idle  = 1'b1;
                    end
                end
                fptl_pkg::MODE_KEYWORD: begin
                    if (kw_mask != 5'b0) begin
                        kw_prog_next = kw_inc;
                        kw_cand_next = kw_mask;
                        if (kw_done_v && !kw_longer) begin
                            pre_v     = 1'b1;
                            pre       = mk_tok(fptl_pkg::KIND_ELEMENTLINE + 4'(kw_done_idx));
                            mode_next = fptl_pkg::MODE_IDLE;
                        end
                    end else if (kw_prog_reg >= fptl_pkg::KW_ELEMENT_LEN) begin
                        // element already complete, the longer keyword fell through
                        pre_v = 1'b1;
                        pre   = mk_tok(fptl_pkg::KIND_ELEMENT);
                        if (kw_prog_reg > fptl_pkg::KW_ELEMENT_LEN) begin
                            sec_v     = 1'b1;
                            err_next  = 1'b1;
                            mode_next = fptl_pkg::MODE_IDLE;
                        end else begin
                            use_idle = 1'b1;
                        end
                    end else begin
                        pre_v     = 1'b1;
                        err_next  = 1'b1;
                        mode_next = fptl_pkg::MODE_IDLE;
                    end
                end
                fptl_pkg::MODE_STRING: begin
                    // whitespace runs collapse to one space
                    if (!(is_space && prev_space_reg)) begin
                        pre_v = 1'b1;
                        if (esc_reg) begin
                            pre      = mk_tok(fptl_pkg::KIND_SCHAR);
                            pre.ch   = str_ch;
                            esc_next = 1'b0;
                        end else if (str_ch == "\\") begin
                            pre      = mk_tok(fptl_pkg::KIND_SCHAR);
                            pre.ch   = str_ch;
                            esc_next = 1'b1;
                        end else if (str_ch == "\"") begin
                            pre       = mk_tok(fptl_pkg::KIND_SEND);
                            mode_next = fptl_pkg::MODE_IDLE;
                        end else begin
                            pre    = mk_tok(fptl_pkg::KIND_SCHAR);
                            pre.ch = str_ch;
                        end
                    end
                end
                default: begin
                    use_idle = 1'b1;
                end
            endcase

            // digit folded into the accumulator, overflow is sticky
            if (do_add && !ovf_reg) begin
                if (add_ovf) begin
                    ovf_next = 1'b1;
                end else begin
                    acc_next = prod[AccW-1:0];
                end
            end

            // between-token handling of this byte
            if (use_idle) begin
                mode_next = id_mode;
                if (id_v) begin
                    sec_v = 1'b1;
                    sec   = mk_tok(id_kind);
                end
                if (id_err) begin
                    err_next = 1'b1;
                end
                if (id_start) begin
                    neg_next = id_neg;
                    acc_next = AccW'(id_d);
                    ovf_next = 1'b0;
                end
                if (id_kw) begin
                    kw_prog_next = 4'd1;
                    kw_cand_next = id_cand;
                end
                if (id_str) begin
                    esc_next = 1'b0;
                end
            end

            prev_word_next  = is_word;
            prev_space_next = is_space;
        end
    end

    // results packed toward the queue
    entry_t     res0, res1;
    logic [1:0] res_cnt;

    always_comb begin
        res_cnt   = 2'({1'b0, pre_v}) + 2'({1'b0, sec_v});
        res0.tok  = pre_v ? pre : sec;
        res0.last = (res_cnt == 2'd1);
        res1.tok  = sec;
        res1.last = 1'b1;
    end

    assign s_ready = (count_reg <= 3'd2);
    assign accept  = s_valid && s_ready;
    assign m_valid = (count_reg != 3'd0);
    assign pop     = m_valid && m_ready;

    // scan state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= fptl_pkg::MODE_IDLE;
            kw_prog_reg    <= 4'd0;
            kw_cand_reg    <= 5'b0;
            prev_word_reg  <= 1'b0;
            prev_space_reg <= 1'b0;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            esc_reg        <= 1'b0;
            err_reg        <= 1'b0;
        end else if (accept) begin
            mode_reg       <= mode_next;
            kw_prog_reg    <= kw_prog_next;
            kw_cand_reg    <= kw_cand_next;
            prev_word_reg  <= prev_word_next;
            prev_space_reg <= prev_space_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            ovf_reg        <= ovf_next;
            esc_reg        <= esc_next;
            err_reg        <= err_next;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end else begin
            if (pop) begin
                head_reg <= head_reg + 2'd1;
            end
            if (accept) begin
                tail_reg <= tail_reg + res_cnt;
            end
            count_reg <= count_reg + (accept ? 3'(res_cnt) : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    // queue payload
    always_ff @(posedge aclk) begin
        if (accept && res_cnt != 2'd0) begin
            fifo_reg[tail_reg] <= res0;
        end
        if (accept && res_cnt == 2'd2) begin
            fifo_reg[tail_reg + 2'd1] <= res1;
        end
    end

    assign m_token_kind      = fifo_reg[head_reg].tok.kind;
    assign m_number_value    = $signed(fifo_reg[head_reg].tok.value);
    assign m_number_overflow = fifo_reg[head_reg].tok.ovf;
    assign m_string_char     = fifo_reg[head_reg].tok.ch;
    assign m_last_of_run     = fifo_reg[head_reg].last;

endmodule

FILE: sv/fptl_checker.sv
// port checker for the footprint token lexer, bound to the top level
module fptl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_char_byte,
    input logic        s_end_of_input,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_token_kind,
    input logic [31:0] m_number_value,
    input logic        m_number_overflow,
    input logic [7:0]  m_string_char,
    input logic        m_last_of_run
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind)
            && $stable(m_number_value) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    // eof always closes the run of its request
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == fptl_pkg::KIND_EOF |-> m_last_of_run)
        else $error("eof not marked last");

    // overflowed number carries zero, and only numbers carry value or flag
    a_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_number_overflow || m_token_kind != fptl_pkg::KIND_NUMBER)
            |-> m_number_value == 32'd0)
        else $error("nonzero value on overflow or non-number");

    a_ovf_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_number_overflow |-> m_token_kind == fptl_pkg::KIND_NUMBER)
        else $error("overflow flag on non-number");

    // only string content carries a byte
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != fptl_pkg::KIND_SCHAR |-> m_string_char == 8'h00)
        else $error("string byte on non-string token");

endmodule

bind footprint_token_lexer_core fptl_checker u_fptl_checker (.*);
